// ===== hdl/catmull_rom_spline_eval_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the spline evaluator.
// ---------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_EVAL_CORE_ASSERT_SVH
`define CATMULL_ROM_SPLINE_EVAL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/crs_pkg.sv =====
// ---------------------------------------------------------------------------
// crs_pkg
// Types and constants of the Catmull-Rom spline evaluator.
// ---------------------------------------------------------------------------
package crs_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int MAX_POINTS_DEF = 64;
  localparam int WGT_WIDTH      = 21;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_TIME_SCALE  = 1'b1;

  localparam logic [6:0]  POINT_COUNT_RST = 7'd1;
  localparam logic [31:0] TIME_SCALE_RST  = 32'd65536;

  typedef struct packed {
    logic                           action;
    logic [5:0]                     point_index;
    logic signed [COORD_WIDTH-1:0]  point_x;
    logic signed [COORD_WIDTH-1:0]  point_y;
    logic signed [COORD_WIDTH-1:0]  point_z;
    logic [31:0]                    eval_time;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic signed [COORD_WIDTH-1:0] curve_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } pt_t;

endpackage

// ===== hdl/crs_point_mem.sv =====
// ---------------------------------------------------------------------------
// crs_point_mem
// Control point table copy: one write port, one registered read port.
// ---------------------------------------------------------------------------
module crs_point_mem #(
  parameter int DEPTH = crs_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(crs_pkg::MAX_POINTS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  crs_pkg::pt_t      wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output crs_pkg::pt_t      rdata_r
);
  import crs_pkg::*;

  pt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hdl/crs_blend.sv =====
// ---------------------------------------------------------------------------
// crs_blend
// Hermite weight generation, weighted products and rounded saturating sum.
// ---------------------------------------------------------------------------
module crs_blend (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        u_i,
  input  logic [31:0]        u2_i,
  input  crs_pkg::pt_t [3:0] pts_i,
  output crs_pkg::out_item_t res_o
);
  import crs_pkg::*;

  localparam int WW = 54;
  localparam int PW = COORD_WIDTH + WGT_WIDTH;
  localparam int SW = PW + 2;
  localparam int RW = SW - 16;
  localparam logic signed [WW-1:0] TWO_U3 = WW'(1) <<< 49;
  localparam logic signed [WW-1:0] RND_W  = WW'(1) <<< 32;
  localparam logic signed [RW-1:0] CMAX   = RW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [RW-1:0] CMIN   = -CMAX - RW'(1);

  logic [15:0]                   u_a_r;
  logic [31:0]                   u2_a_r;
  logic [47:0]                   u3_a_r;
  pt_t [3:0]                     pts_a_r;
  logic signed [WGT_WIDTH-1:0]   w_b_r [4];
  pt_t [3:0]                     pts_b_r;
  logic signed [PW-1:0]          prod_c_r [4][3];

  logic signed [WW-1:0]          c1, c2, c3;
  logic signed [WW-1:0]          wf [4];
  logic signed [WGT_WIDTH-1:0]   w_nxt [4];
  logic signed [COORD_WIDTH-1:0] pc [4][3];
  logic signed [SW-1:0]          sum [3];
  logic signed [RW-1:0]          rs [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  always_comb begin
    c1 = $signed(WW'(u_a_r));
    c2 = $signed(WW'(u2_a_r));
    c3 = $signed(WW'(u3_a_r));
    wf[0] = -c3 + (c2 <<< 17) - (c1 <<< 32);
    wf[1] = c3 + (c3 <<< 1) - (c2 <<< 18) - (c2 <<< 16) + TWO_U3;
    wf[2] = -c3 - (c3 <<< 1) + (c2 <<< 18) + (c1 <<< 32);
    wf[3] = c3 - (c2 <<< 16);
    for (int k = 0; k < 4; k++) begin
      wf[k]    = wf[k] + RND_W;
      w_nxt[k] = wf[k][WW-1:33];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pc[k][0] = pts_b_r[k].x;
      pc[k][1] = pts_b_r[k].y;
      pc[k][2] = pts_b_r[k].z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_a_r   <= u_i;
      u2_a_r  <= u2_i;
      u3_a_r  <= 48'(u2_i) * 48'(u_i);
      pts_a_r <= pts_i;
      for (int k = 0; k < 4; k++) begin
        w_b_r[k] <= w_nxt[k];
      end
      pts_b_r <= pts_a_r;
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_c_r[k][c] <= w_b_r[k] * pc[k][c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SW'(prod_c_r[0][c]) + SW'(prod_c_r[1][c]) + SW'(prod_c_r[2][c])
             + SW'(prod_c_r[3][c]) + SW'(32768);
      rs[c]  = sum[c][SW-1:16];
      if (rs[c] > CMAX) begin
        sat[c] = CMAX[COORD_WIDTH-1:0];
      end else if (rs[c] < CMIN) begin
        sat[c] = CMIN[COORD_WIDTH-1:0];
      end else begin
        sat[c] = rs[c][COORD_WIDTH-1:0];
      end
    end
    res_o.curve_x = sat[0];
    res_o.curve_y = sat[1];
    res_o.curve_z = sat[2];
  end

endmodule

// ===== hdl/catmull_rom_spline_eval_core.sv =====
// ---------------------------------------------------------------------------
// catmull_rom_spline_eval_core
// Catmull-Rom evaluator over a table of 3D control points in Q16.16.
// ---------------------------------------------------------------------------
// Takes one item per clock when not held, writes and evaluates alike. The
// control point table is held in four identical memory copies, each written
// by every in-range write item, so that the four neighbor points are read in
// the same cycle. The whole pipeline holds only while the output register is
// full and not taken. Table entries are undefined until written; there is no
// clearing pass after reset.
`include "catmull_rom_spline_eval_core_assert.svh"

module catmull_rom_spline_eval_core #(
  parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import crs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  logic [6:0]    point_count_r;
  logic [31:0]   time_scale_r;

  logic          v1_r, act1_r;
  logic [5:0]    slot1_r;
  pt_t           pt1_r;
  logic [63:0]   prod1_r;
  logic          v2_r, v3_r, v4_r, v5_r;
  logic [15:0]   u2s_u_r;
  logic [31:0]   u2s_u2_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic          adv, accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] rd_idx [4];
  logic [15:0]   u1;
  pt_t [3:0]     rd_pts;
  out_item_t     blend_res;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign u1       = prod1_r[31:16];
  assign wr_en    = adv && v1_r && (act1_r == ACT_WRITE) && (int'(slot1_r) < MAX_POINTS);
  assign rd_en    = adv && v1_r && (act1_r == ACT_EVAL);

  always_comb begin
    int cnt;
    logic signed [33:0] s;
    cnt = int'(point_count_r);
    if (cnt < 1) begin
      cnt = 1;
    end
    if (cnt > MAX_POINTS) begin
      cnt = MAX_POINTS;
    end
    last_idx = AW'(cnt - 1);
    for (int k = 0; k < 4; k++) begin
      s = $signed({2'b00, prod1_r[63:32]}) + 34'(k) - 34'sd1;
      if (s < 0) begin
        rd_idx[k] = '0;
      end else if (s > $signed(34'(last_idx))) begin
        rd_idx[k] = last_idx;
      end else begin
        rd_idx[k] = AW'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RST;
      time_scale_r  <= TIME_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count_r <= cfg_wdata[6:0];
        REG_TIME_SCALE:  time_scale_r  <= cfg_wdata;
        default:         point_count_r <= point_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r && (act1_r == ACT_EVAL);
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act1_r  <= in_data.action;
      slot1_r <= in_data.point_index;
      pt1_r   <= '{x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};
      prod1_r <= 64'(in_data.eval_time) * 64'(time_scale_r);
    end
    if (adv) begin
      u2s_u_r  <= u1;
      u2s_u2_r <= 32'(u1) * 32'(u1);
      if (v5_r) begin
        out_data_r <= blend_res;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_mem
    crs_point_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
    ) u_mem (
      .clk     (clk),
      .we      (wr_en),
      .waddr   (AW'(slot1_r)),
      .wdata   (pt1_r),
      .re      (rd_en),
      .raddr   (rd_idx[k]),
      .rdata_r (rd_pts[k])
    );
  end

  crs_blend u_blend (
    .clk   (clk),
    .en    (adv),
    .u_i   (u2s_u_r),
    .u2_i  (u2s_u2_r),
    .pts_i (rd_pts),
    .res_o (blend_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CRS_ASSERT_IMPL(a_rd_in_range, clk, rst_n, rd_en, (rd_idx[0] <= last_idx) && (rd_idx[3] <= last_idx), "read index past last point")
  `CRS_ASSERT_NEXT(a_eval_moves, clk, rst_n, adv && v1_r && (act1_r == ACT_EVAL), v2_r, "evaluate item lost in pipeline")
  `CRS_ASSERT_NEXT(a_write_no_result, clk, rst_n, adv && v1_r && (act1_r == ACT_WRITE), !v2_r, "write item produced a result")
  `CRS_ASSERT_IMPL(a_out_source, clk, rst_n, $rose(out_valid_r), $past(v5_r), "result without evaluate item")

endmodule
